@@ design/kgs_pkg.sv @@
// kgs_pkg: shared constants, codes and types of the glow spot renderer
`timescale 1ns / 1ps

package kgs_pkg;

  // table size and register defaults
  localparam int unsigned SPOT_COUNT   = 10;
  localparam int unsigned LIFE_RESET   = 900;
  localparam int unsigned RADIUS_RESET = 1536;
  localparam int unsigned SPEED_RESET  = 256;
  localparam int unsigned TICK_CLAMP   = 100;
  localparam int unsigned FULL_LEVEL   = 255;

  // field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned AGE_W   = 17;
  localparam int unsigned LIFE_W  = 16;
  localparam int unsigned RAD_W   = 15;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // divider widths: quotient is always below 256
  localparam int unsigned NUM_W = 38;
  localparam int unsigned DEN_W = 30;
  localparam int unsigned QUO_W = 8;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // command codes carried in tuser
  localparam logic [CMD_W-1:0] CMD_PRESS  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RENDER = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIFE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 2'd2;

  // one entry of the spot memory, x in the lowest bits
  typedef struct packed {
    logic [AGE_W-1:0] age;
    logic [POS_W-1:0] y;
    logic [POS_W-1:0] x;
  } spot_t;

  // divider request and response
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quot;
  } div_rsp_t;

endpackage

@@ design/kgs_ram.sv @@
// kgs_ram: generic simple dual port RAM with registered read
`timescale 1ns / 1ps

module kgs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/kgs_div.sv @@
// kgs_div: iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module kgs_div (
  input  logic              clk,
  input  logic              rst_n,
  input  kgs_pkg::div_req_t req,
  output kgs_pkg::div_rsp_t rsp
);

  logic [kgs_pkg::NUM_W-1:0] rem_r;
  logic [kgs_pkg::NUM_W-1:0] dsh_r;
  logic [kgs_pkg::QUO_W-1:0] quot_r;
  logic [2:0]                cnt_r;
  logic                      busy_r;
  logic                      done_r;
  logic                      fits;

  // trial subtract of the shifted divisor
  assign fits = rem_r >= dsh_r;

  // control: start reloads, done pulses after the last bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd7;
      end else if (busy_r) begin
        if (cnt_r == 3'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 3'd1;
        end
      end
    end
  end

  // datapath: remainder, shifted divisor and quotient bits msb first
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r  <= req.num;
      dsh_r  <= {1'b0, req.den, 7'b0};
      quot_r <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      quot_r <= {quot_r[kgs_pkg::QUO_W-2:0], fits};
      dsh_r  <= {1'b0, dsh_r[kgs_pkg::NUM_W-1:1]};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule

@@ design/keypress_glow_spot_renderer.sv @@
// keypress_glow_spot_renderer: top level, spot table sequencer and render datapath
// One item at a time, taken in idle. Press scans occupied slots, then writes the first free
// slot, or the oldest spot when full; tick rewrites the age of each live slot; render skips
// free slots and spots past their lifespan, starts the envelope divide and distance terms
// for every other spot and the falloff divide for spots in range, then waits for a free
// output register. Render time is set by the shared 8-step divider, twice per spot in range.
// Reset (sync, active low) clears alive bits and output valid, loads register defaults.
`timescale 1ns / 1ps

module keypress_glow_spot_renderer #(
  parameter int unsigned SPOT_COUNT = kgs_pkg::SPOT_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transaction
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // pos_x[15:0], pos_y[31:16], tick_ms[47:32]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  // result transaction
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // red_level[7:0]
  // configuration writes
  input  logic                              cfg_we,
  input  logic [kgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [kgs_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned IW = (SPOT_COUNT > 1) ? $clog2(SPOT_COUNT) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(SPOT_COUNT - 1);

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_P_RD   = 4'd1;
  localparam logic [3:0] S_P_CHK  = 4'd2;
  localparam logic [3:0] S_P_WR   = 4'd3;
  localparam logic [3:0] S_R_RD   = 4'd4;
  localparam logic [3:0] S_R_LD   = 4'd5;
  localparam logic [3:0] S_R_SQ1  = 4'd6;
  localparam logic [3:0] S_R_SQ2  = 4'd7;
  localparam logic [3:0] S_R_NEAR = 4'd8;
  localparam logic [3:0] S_R_WE   = 4'd9;
  localparam logic [3:0] S_R_MUL  = 4'd10;
  localparam logic [3:0] S_R_WC   = 4'd11;
  localparam logic [3:0] S_R_OUT  = 4'd12;
  localparam logic [3:0] S_T_RD   = 4'd13;
  localparam logic [3:0] S_T_WR   = 4'd14;

  logic [3:0] state_r, state_nxt;

  // configuration registers
  logic [kgs_pkg::LIFE_W-1:0]  life_r;
  logic [kgs_pkg::RAD_W-1:0]   radius_r;
  logic [kgs_pkg::SPEED_W-1:0] speed_r;
  logic [kgs_pkg::LIFE_W-1:0]  life_eff;

  // per item working registers
  logic [IW-1:0]              idx_r;
  logic [IW-1:0]              pick_r;
  logic [kgs_pkg::AGE_W-1:0]  oldest_r;
  logic [kgs_pkg::POS_W-1:0]  x_r;
  logic [kgs_pkg::POS_W-1:0]  y_r;
  logic [14:0]                step_r;
  logic [kgs_pkg::DEN_W-1:0]  r2_r;
  logic signed [16:0]         dx_r;
  logic signed [16:0]         dy_r;
  logic [33:0]                dxsq_r;
  logic [34:0]                d2_r;
  logic [kgs_pkg::DEN_W-1:0]  diff_r;
  logic [kgs_pkg::LEVEL_W-1:0] sum_r;
  logic [SPOT_COUNT-1:0]      alive_r;

  // output register
  logic                        out_valid_r;
  logic [kgs_pkg::LEVEL_W-1:0] out_data_r;

  // memory and divider hookup
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  kgs_pkg::spot_t      ram_wdata;
  kgs_pkg::spot_t      ram_rdata;
  kgs_pkg::div_req_t   div_req;
  kgs_pkg::div_rsp_t   div_rsp;

  logic        accept;
  logic        last;
  logic        alive_cur;
  logic        adv;
  logic        out_load;
  logic        too_old;
  logic        far;
  logic [6:0]  dt_clamp;
  logic [15:0] spd_eff;
  logic [22:0] step_prod;
  logic [24:0] age_x255;
  logic [7:0]  env;
  logic signed [33:0] dx_sq;
  logic signed [33:0] dy_sq;
  logic [17:0] age_sum;
  logic [kgs_pkg::AGE_W-1:0] age_sat;
  logic [8:0]  acc;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign last      = (idx_r == LAST_IDX);
  assign alive_cur = alive_r[idx_r];
  assign life_eff  = (life_r == '0) ? kgs_pkg::LIFE_W'(1) : life_r;
  assign out_load  = (state_r == S_R_OUT) && (!out_valid_r || out_tready);

  // tick step from the incoming item
  assign dt_clamp  = (in_tdata[47:32] > 16'(kgs_pkg::TICK_CLAMP)) ?
                     7'(kgs_pkg::TICK_CLAMP) : in_tdata[38:32];
  assign spd_eff   = (speed_r == '0) ? 16'(kgs_pkg::SPEED_RESET) : speed_r;
  assign step_prod = 23'(dt_clamp) * 23'(spd_eff);

  // render arithmetic
  assign too_old  = ram_rdata.age >= {1'b0, life_eff};
  assign age_x255 = {ram_rdata.age, 8'b0} - {8'b0, ram_rdata.age};
  assign dx_sq    = dx_r * dx_r;
  assign dy_sq    = dy_r * dy_r;
  assign far      = d2_r >= {5'b0, r2_r};
  assign env      = 8'(kgs_pkg::FULL_LEVEL) - div_rsp.quot;
  assign acc      = {1'b0, sum_r} + {1'b0, div_rsp.quot};

  // tick arithmetic
  assign age_sum = {1'b0, ram_rdata.age} + 18'(step_r);
  assign age_sat = age_sum[17] ? kgs_pkg::AGE_MAX : age_sum[16:0];

  // sequencer and memory / divider control
  always_comb begin
    state_nxt = state_r;
    adv       = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = ram_rdata;
    div_req   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_tuser)
            kgs_pkg::CMD_PRESS:  state_nxt = S_P_RD;
            kgs_pkg::CMD_RENDER: state_nxt = S_R_RD;
            kgs_pkg::CMD_TICK:   state_nxt = S_T_RD;
            default:             state_nxt = S_IDLE;
          endcase
        end
      end
      S_P_RD: begin
        state_nxt = alive_cur ? S_P_CHK : S_P_WR;
      end
      S_P_CHK: begin
        adv       = 1'b1;
        state_nxt = last ? S_P_WR : S_P_RD;
      end
      S_P_WR: begin
        ram_we        = 1'b1;
        ram_waddr     = pick_r;
        ram_wdata.x   = x_r;
        ram_wdata.y   = y_r;
        ram_wdata.age = '0;
        state_nxt     = S_IDLE;
      end
      S_R_RD: begin
        if (alive_cur) begin
          state_nxt = S_R_LD;
        end else begin
          adv       = 1'b1;
          state_nxt = last ? S_R_OUT : S_R_RD;
        end
      end
      S_R_LD: begin
        if (too_old) begin
          adv       = 1'b1;
          state_nxt = last ? S_R_OUT : S_R_RD;
        end else begin
          div_req.start = 1'b1;
          div_req.num   = kgs_pkg::NUM_W'(age_x255);
          div_req.den   = kgs_pkg::DEN_W'(life_eff);
          state_nxt     = S_R_SQ1;
        end
      end
      S_R_SQ1: state_nxt = S_R_SQ2;
      S_R_SQ2: state_nxt = S_R_NEAR;
      S_R_NEAR: begin
        if (far) begin
          adv       = 1'b1;
          state_nxt = last ? S_R_OUT : S_R_RD;
        end else begin
          state_nxt = S_R_WE;
        end
      end
      S_R_WE: begin
        if (div_rsp.done) begin
          state_nxt = S_R_MUL;
        end
      end
      S_R_MUL: begin
        div_req.start = 1'b1;
        div_req.num   = kgs_pkg::NUM_W'(env) * kgs_pkg::NUM_W'(diff_r);
        div_req.den   = r2_r;
        state_nxt     = S_R_WC;
      end
      S_R_WC: begin
        if (div_rsp.done) begin
          adv       = 1'b1;
          state_nxt = last ? S_R_OUT : S_R_RD;
        end
      end
      S_R_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      S_T_RD: begin
        if (alive_cur) begin
          state_nxt = S_T_WR;
        end else begin
          adv       = 1'b1;
          state_nxt = last ? S_IDLE : S_T_RD;
        end
      end
      S_T_WR: begin
        ram_we        = 1'b1;
        ram_wdata.age = age_sat;
        adv           = 1'b1;
        state_nxt     = last ? S_IDLE : S_T_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alive_r     <= '0;
      out_valid_r <= 1'b0;
      life_r      <= kgs_pkg::LIFE_W'(kgs_pkg::LIFE_RESET);
      radius_r    <= kgs_pkg::RAD_W'(kgs_pkg::RADIUS_RESET);
      speed_r     <= kgs_pkg::SPEED_W'(kgs_pkg::SPEED_RESET);
    end else begin
      state_r <= state_nxt;
      // spawn marks the slot live, tick retires spots at their lifespan
      if (state_r == S_P_WR) begin
        alive_r[pick_r] <= 1'b1;
      end else if (state_r == S_T_WR && age_sat >= {1'b0, life_eff}) begin
        alive_r[idx_r] <= 1'b0;
      end
      // output register
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          kgs_pkg::REG_LIFE:   life_r   <= cfg_data;
          kgs_pkg::REG_RADIUS: radius_r <= cfg_data[kgs_pkg::RAD_W-1:0];
          kgs_pkg::REG_SPEED:  speed_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // working registers of the current item
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r      <= in_tdata[15:0];
      y_r      <= in_tdata[31:16];
      step_r   <= step_prod[22:8];
      r2_r     <= kgs_pkg::DEN_W'(radius_r) * kgs_pkg::DEN_W'(radius_r);
      idx_r    <= '0;
      pick_r   <= '0;
      oldest_r <= '0;
      sum_r    <= '0;
    end else if (adv && !last) begin
      idx_r <= idx_r + IW'(1);
    end
    // slot choice: first free, else oldest with the later slot winning ties
    if (state_r == S_P_RD && !alive_cur) begin
      pick_r <= idx_r;
    end
    if (state_r == S_P_CHK && ram_rdata.age >= oldest_r) begin
      oldest_r <= ram_rdata.age;
      pick_r   <= idx_r;
    end
    // distance terms while the envelope divide runs
    if (state_r == S_R_LD) begin
      dx_r <= $signed({x_r[15], x_r}) - $signed({ram_rdata.x[15], ram_rdata.x});
      dy_r <= $signed({y_r[15], y_r}) - $signed({ram_rdata.y[15], ram_rdata.y});
    end
    if (state_r == S_R_SQ1) begin
      dxsq_r <= dx_sq;
    end
    if (state_r == S_R_SQ2) begin
      d2_r <= {1'b0, dxsq_r} + {1'b0, dy_sq};
    end
    if (state_r == S_R_NEAR) begin
      diff_r <= r2_r - d2_r[kgs_pkg::DEN_W-1:0];
    end
    // saturating accumulate of the spot contribution
    if (state_r == S_R_WC && div_rsp.done) begin
      sum_r <= acc[8] ? 8'(kgs_pkg::FULL_LEVEL) : acc[7:0];
    end
    if (out_load) begin
      out_data_r <= sum_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // spot table memory, read always at the current slot
  kgs_ram #(
    .WIDTH ($bits(kgs_pkg::spot_t)),
    .DEPTH (SPOT_COUNT)
  ) u_spot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  // shared divider for envelope and falloff
  kgs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

@@ design/kgs_checker.sv @@
// kgs_checker: port level assertions for the glow spot renderer, with bind
`timescale 1ns / 1ps

module kgs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [1:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // a stalled result holds its value
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // a real command leaves the block busy in the cycle after it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser != kgs_pkg::CMD_NONE) |=> !in_tready)
    else $error("input taken again right after a command");

  // a new result only comes out of a busy render
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without a render in progress");

  // reset leaves the block idle with no pending result
  assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind keypress_glow_spot_renderer kgs_checker u_kgs_checker (.*);
